// ===== rtl/rdsm_pkg.sv =====
// shared types and constants for the dot-star pattern matcher
package rdsm_pkg;

   localparam int PATTERN_MAX_DEFAULT = 32;
   localparam int LEN_W               = 6;
   localparam int CHAR_W              = 8;
   localparam int WORD_W              = 64;
   localparam int WORD_COUNT          = 4;
   localparam int CSR_INDEX_W         = 3;
   localparam int REQ_TUSER_W         = 2;
   localparam int RSP_TDATA_W         = 8;

   localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_STAR = 8'h2A;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_WORD_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_WORD_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_WORD_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_WORD_3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 3'd4;

   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] char_value;
      logic              first_char;
      logic              empty_text;
      logic              new1;
      logic              new2;
      logic              emp1;
      logic              emp2;
      logic              old1;
      logic              matched;
   } rdsm_link_type;

endpackage

// ===== rtl/rdsm_cell.sv =====
// one pattern position of the matcher chain: holds one row bit, passes the wavefront on
module rdsm_cell
   import rdsm_pkg::*;
#(
   parameter int CELL_INDEX = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [CHAR_W-1:0] pat_cur,
   input  logic [CHAR_W-1:0] pat_prev,
   input  logic [LEN_W-1:0]  len,
   input  rdsm_link_type     up_link,
   output rdsm_link_type     down_link
);

   localparam logic [LEN_W-1:0] POS      = LEN_W'(CELL_INDEX);
   localparam bit               HAS_PREV = (CELL_INDEX >= 2);

   logic          bit_ff, bit_in;
   rdsm_link_type down_ff, down_in;
   logic          in_len, cur_star, cur_any, prev_any;
   logic          emp, old_own, adv, nb;

   always_comb begin
      in_len   = (POS <= len);
      cur_star = (pat_cur == CHAR_STAR);
      cur_any  = (pat_cur == CHAR_DOT) || (pat_cur == up_link.char_value);
      prev_any = (pat_prev == CHAR_DOT) || (pat_prev == up_link.char_value);
      emp      = in_len && cur_star && HAS_PREV && up_link.emp2;
      old_own  = up_link.first_char ? emp : (bit_ff && in_len);
      if (cur_star) begin
         adv = HAS_PREV && (up_link.new2 || (prev_any && old_own));
      end else begin
         adv = cur_any && up_link.old1;
      end
      adv = adv && in_len;
      nb  = up_link.empty_text ? emp : adv;

      down_in            = up_link;
      down_in.new1       = nb;
      down_in.new2       = up_link.new1;
      down_in.emp1       = emp;
      down_in.emp2       = up_link.emp1;
      down_in.old1       = old_own;
      down_in.matched    = (POS == len) ? nb : up_link.matched;

      bit_in = (advance && up_link.valid) ? nb : bit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff  <= 1'b0;
         down_ff <= '0;
      end else if (advance) begin
         bit_ff  <= bit_in;
         down_ff <= down_in;
      end
   end

   assign down_link = down_ff;

   a_beat_moves: assert property (@(posedge clock) disable iff (reset)
      advance && up_link.valid |=> down_link.valid)
      else $error("beat lost in cell");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(down_link) && $stable(bit_ff))
      else $error("cell moved while stalled");

   a_above_len: assert property (@(posedge clock) disable iff (reset)
      advance && up_link.valid && (POS > len) |=> !bit_ff)
      else $error("row bit set above pattern length");

endmodule

// ===== rtl/regex_dot_star_matcher_top.sv =====
// top level of the dot-star pattern matcher: config registers, head stage and cell chain
//
// Whole-string matcher for patterns of literal bytes, '.' and '*'.
// csr_*: write channel, csr_index 0..3 load pattern bytes 0..31 (eight per
//   word, byte k in bits 8k+7..8k), index 4 loads the pattern length;
//   csr_ready is always high. Write only while no beat is in flight.
// req_*: one text byte per beat in req_tdata, req_tuser[0] restarts the text
//   before this byte, req_tuser[1] marks a zero-length text.
// rsp_*: one beat per request beat, rsp_tdata[0] set when the text so far
//   matches the whole pattern.
// Each pattern position is one cell of a chain; a request beat travels as a
//   wavefront, one cell per cycle, through the head stage and then each cell,
//   and one beat per cycle is sustained while the chain is not held.
// When rsp_tready is low with a result waiting, the whole chain holds and
//   req_tready drops until the result is taken.
// Reset clears the pattern, the length and the match row; a byte sent after
//   reset without a restart reports no match.
module regex_dot_star_matcher_top
   import rdsm_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [CHAR_W-1:0]      req_tdata,   // char_value
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // first_char, empty_text
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // matched, zero fill
);

   logic [WORD_W-1:0] pattern_word_ff [WORD_COUNT];
   logic [LEN_W-1:0]  pattern_length_ff;
   logic              row0_ff;
   rdsm_link_type     head_ff, head_in;
   logic [LEN_W-1:0]  len_eff;
   logic              advance;
   logic [CHAR_W-1:0] pat_bytes [PATTERN_MAX];
   rdsm_link_type     links [PATTERN_MAX+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < WORD_COUNT; w++) begin
            pattern_word_ff[w] <= '0;
         end
         pattern_length_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_WORD_0: pattern_word_ff[0] <= csr_wdata;
            CSR_PATTERN_WORD_1: pattern_word_ff[1] <= csr_wdata;
            CSR_PATTERN_WORD_2: pattern_word_ff[2] <= csr_wdata;
            CSR_PATTERN_WORD_3: pattern_word_ff[3] <= csr_wdata;
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign len_eff = (pattern_length_ff > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                              : pattern_length_ff;

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_bytes
      assign pat_bytes[k] = pattern_word_ff[k/8][(k%8)*8 +: 8];
   end

   assign advance    = !links[PATTERN_MAX].valid || rsp_tready;
   assign req_tready = advance;

   // head stage: row bit zero and the seed of the empty-text row
   always_comb begin
      head_in            = '0;
      head_in.valid      = req_tvalid;
      head_in.char_value = req_tdata;
      head_in.first_char = req_tuser[0];
      head_in.empty_text = req_tuser[1];
      head_in.new1       = req_tuser[1];
      head_in.new2       = 1'b0;
      head_in.emp1       = 1'b1;
      head_in.emp2       = 1'b0;
      head_in.old1       = req_tuser[0] ? 1'b1 : row0_ff;
      head_in.matched    = (len_eff == '0) ? req_tuser[1] : 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff <= 1'b0;
         head_ff <= '0;
      end else if (advance) begin
         head_ff <= head_in;
         if (req_tvalid) begin
            row0_ff <= req_tuser[1];
         end
      end
   end

   assign links[0] = head_ff;

   for (genvar g = 1; g <= PATTERN_MAX; g++) begin : g_cells
      logic [CHAR_W-1:0] prev_byte;
      if (g >= 2) begin : g_prev
         assign prev_byte = pat_bytes[g-2];
      end else begin : g_noprev
         assign prev_byte = '0;
      end
      rdsm_cell #(
         .CELL_INDEX(g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .pat_cur   (pat_bytes[g-1]),
         .pat_prev  (prev_byte),
         .len       (len_eff),
         .up_link   (links[g-1]),
         .down_link (links[g])
      );
   end

   assign rsp_tvalid = links[PATTERN_MAX].valid;
   assign rsp_tdata  = {{(RSP_TDATA_W-1){1'b0}}, links[PATTERN_MAX].matched};

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with free output");

   a_head_loaded: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> links[0].valid)
      else $error("accepted beat missing from head stage");

endmodule
